### design/ffd_pkg.sv
// ============================================================================
// ffd_pkg: shared definitions for the fractional feedback delay
// Store geometry, multiplier operand widths and the store request bundle.
// ============================================================================
package ffd_pkg;

    // Depth of the circular sample store. Addresses wrap by plain binary
    // overflow, so the depth is kept a power of two.
    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    // The fill count must be able to hold the depth itself.
    localparam int FILL_W      = ADDR_W + 1;

    localparam int SAMPLE_W    = 16;
    localparam int MUL_W       = 17;
    localparam int PROD_W      = 2 * MUL_W;

    // APB address width: five 32-bit registers at byte offsets 0 to 16.
    localparam int CFG_ADDR_W  = 5;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [ADDR_W-1:0]          store_addr_t;
    typedef logic signed [MUL_W-1:0]    operand_t;
    typedef logic signed [PROD_W-1:0]   product_t;

    // One read and one write per cycle on the sample store.
    typedef struct packed {
        logic        rd_en;
        store_addr_t rd_addr;
        logic        wr_en;
        store_addr_t wr_addr;
        sample_t     wr_data;
    } store_req_t;

endpackage

### design/ffd_store.sv
// ============================================================================
// ffd_store: circular sample store
// Single write port and single read port with registered read data.
// ============================================================================
module ffd_store
(
    input  logic               clk,
    input  ffd_pkg::store_req_t req,
    output ffd_pkg::sample_t   rd_data
);

    ffd_pkg::sample_t mem [ffd_pkg::STORE_DEPTH];
    ffd_pkg::sample_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/ffd_mul.sv
// ============================================================================
// ffd_mul: shared signed multiplier
// 17 x 17 signed product, registered, held while the enable is low.
// ============================================================================
module ffd_mul
(
    input  logic              clk,
    input  logic              en,
    input  ffd_pkg::operand_t a,
    input  ffd_pkg::operand_t b,
    output ffd_pkg::product_t product
);

    ffd_pkg::product_t product_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            product_reg <= a * b;
        end
    end

    assign product = product_reg;

endmodule

### design/fractional_feedback_delay.sv
// ============================================================================
// fractional_feedback_delay: audio delay with fractional tap and feedback
// Reads two neighboring store entries, interpolates them by the fractional
// delay, writes input plus scaled feedback back into the store and emits a
// blend of the stored value and the interpolated tap.
// ============================================================================
//
//  Channel   Signals                                    Direction
//  --------  -----------------------------------------  ---------
//  input     in_valid, in_ready, sample_in              in
//  output    out_valid, out_ready, sample_out           out
//  config    psel, penable, pwrite, paddr, pwdata,      in/out
//            prdata, pready
//
//  The sequencer takes no new input until the current result is registered
//  at the output. Each input takes two store reads, then four passes
//  through the shared 17 x 17 multiplier with rounding steps between them.
//  in_ready is high only while the sequencer is idle. A waiting result does
//  not block the next input; the sequencer stalls in its last step until it
//  is taken. Reset is asynchronous; a fill count marks entries still zero.
//
module fractional_feedback_delay
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ffd_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [15:0]              sample_in,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [15:0]              sample_out
);

    localparam int SUM_W = 19;
    localparam int ACC_W = ffd_pkg::PROD_W + 1;

    // Register map, word index taken from paddr[4:2].
    typedef enum logic [2:0] {
        REG_DELAY_WHOLE    = 3'd0,
        REG_DELAY_FRACTION = 3'd1,
        REG_FEEDBACK_GAIN  = 3'd2,
        REG_TAP_GAIN       = 3'd3,
        REG_MIX_GAIN       = 3'd4
    } cfg_reg_t;

    // Sequencer steps, in order.
    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_DIFF,
        S_EST,
        S_FB,
        S_STO,
        S_MIX,
        S_TAP,
        S_OUT
    } state_t;

    // Saturate a widened sum to the 16-bit sample range.
    function automatic ffd_pkg::sample_t sat16(input logic signed [SUM_W-1:0] v);
        ffd_pkg::sample_t r;
        if (v > 19'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -19'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [9:0]        delay_whole_reg;
    logic [15:0]       delay_fraction_reg;
    ffd_pkg::sample_t  feedback_gain_reg;
    ffd_pkg::sample_t  tap_gain_reg;
    ffd_pkg::sample_t  mix_gain_reg;
    cfg_reg_t          cfg_idx;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign cfg_idx   = cfg_reg_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_whole_reg    <= '0;
            delay_fraction_reg <= '0;
            feedback_gain_reg  <= '0;
            tap_gain_reg       <= '0;
            mix_gain_reg       <= 16'sd16384;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_DELAY_WHOLE:    delay_whole_reg    <= pwdata[9:0];
                REG_DELAY_FRACTION: delay_fraction_reg <= pwdata[15:0];
                REG_FEEDBACK_GAIN:  feedback_gain_reg  <= pwdata[15:0];
                REG_TAP_GAIN:       tap_gain_reg       <= pwdata[15:0];
                REG_MIX_GAIN:       mix_gain_reg       <= pwdata[15:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_DELAY_WHOLE:    prdata = {22'd0, delay_whole_reg};
            REG_DELAY_FRACTION: prdata = {16'd0, delay_fraction_reg};
            REG_FEEDBACK_GAIN:  prdata = {16'd0, feedback_gain_reg};
            REG_TAP_GAIN:       prdata = {16'd0, tap_gain_reg};
            REG_MIX_GAIN:       prdata = {16'd0, mix_gain_reg};
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer state and datapath registers
    // ------------------------------------------------------------------
    state_t                      state_reg, state_next;
    ffd_pkg::store_addr_t        wp_reg, wp_next;
    logic [ffd_pkg::FILL_W-1:0]  fill_count_reg, fill_count_next;
    logic                        out_valid_reg, out_valid_next;
    ffd_pkg::sample_t            sample_out_reg, sample_out_next;

    ffd_pkg::sample_t            x_reg;
    ffd_pkg::sample_t            y1_reg;
    ffd_pkg::sample_t            est_reg;
    ffd_pkg::sample_t            stored_reg;
    ffd_pkg::product_t           acc_reg;

    ffd_pkg::store_req_t         store_req;
    ffd_pkg::sample_t            rd_data;
    logic                        mul_en;
    ffd_pkg::operand_t           mul_a;
    ffd_pkg::operand_t           mul_b;
    ffd_pkg::product_t           product;

    ffd_pkg::store_addr_t        back;
    logic [ffd_pkg::FILL_W-1:0]  back_ext;
    logic                        valid1;
    logic                        valid0;
    ffd_pkg::sample_t            y0_sel;

    ffd_pkg::product_t           rnd16_sum;
    ffd_pkg::product_t           rnd16;
    ffd_pkg::sample_t            est_next;
    ffd_pkg::product_t           rnd14_sum;
    ffd_pkg::product_t           rnd14;
    logic signed [SUM_W-1:0]     fb_sum;
    ffd_pkg::sample_t            stored_next;
    logic signed [ACC_W-1:0]     acc_sum;
    logic signed [ACC_W-1:0]     out_rnd_sum;
    logic signed [ACC_W-1:0]     out_rnd;
    logic                        in_accept;
    logic                        out_free;

    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // The whole delay wraps modulo the store depth.
    assign back     = ffd_pkg::ADDR_W'(delay_whole_reg);
    assign back_ext = ffd_pkg::FILL_W'(back);

    // Since reset the store has been written at consecutive positions ending
    // just behind the write pointer. An entry that lies further back than the
    // fill count has never been written and reads as zero. With a zero delay
    // the newer tap sits on the oldest entry, which is written only once the
    // store has wrapped.
    assign valid1 = (back == '0)
                  ? (fill_count_reg == ffd_pkg::FILL_W'(ffd_pkg::STORE_DEPTH))
                  : ((back_ext - ffd_pkg::FILL_W'(1)) < fill_count_reg);
    assign valid0 = back_ext < fill_count_reg;
    assign y0_sel = valid0 ? rd_data : '0;

    // Interpolation: y1 + round((y0 - y1) * fraction / 2^16).
    assign rnd16_sum = product + $signed(ffd_pkg::PROD_W'(32'd32768));
    assign rnd16     = rnd16_sum >>> 16;
    assign est_next  = y1_reg + rnd16[15:0];

    // Feedback: input + round(est * feedback / 2^14), saturated.
    assign rnd14_sum   = product + $signed(ffd_pkg::PROD_W'(32'd8192));
    assign rnd14       = rnd14_sum >>> 14;
    assign fb_sum      = SUM_W'(x_reg) + rnd14[SUM_W-1:0];
    assign stored_next = sat16(fb_sum);

    // Output: round((stored * mix + est * tap) / 2^14), saturated.
    assign acc_sum     = ACC_W'(acc_reg) + ACC_W'(product);
    assign out_rnd_sum = acc_sum + $signed(ACC_W'(32'd8192));
    assign out_rnd     = out_rnd_sum >>> 14;

    always_comb
    begin
        state_next         = state_reg;
        wp_next            = wp_reg;
        fill_count_next    = fill_count_reg;
        out_valid_next     = out_valid_reg;
        sample_out_next    = sample_out_reg;

        store_req.rd_en    = 1'b0;
        store_req.rd_addr  = wp_reg - back;
        store_req.wr_en    = 1'b0;
        store_req.wr_addr  = wp_reg;
        store_req.wr_data  = stored_next;

        mul_en = 1'b0;
        mul_a  = ffd_pkg::MUL_W'(est_reg);
        mul_b  = ffd_pkg::MUL_W'(feedback_gain_reg);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                // Fetch the newer tap.
                if (in_accept)
                begin
                    store_req.rd_en = 1'b1;
                    state_next      = S_RD0;
                end
            end
            S_RD0:
            begin
                // Fetch the entry one further back.
                store_req.rd_en   = 1'b1;
                store_req.rd_addr = wp_reg - back - ffd_pkg::ADDR_W'(1);
                state_next        = S_DIFF;
            end
            S_DIFF:
            begin
                mul_en     = 1'b1;
                mul_a      = ffd_pkg::MUL_W'(y0_sel) - ffd_pkg::MUL_W'(y1_reg);
                mul_b      = $signed({1'b0, delay_fraction_reg});
                state_next = S_EST;
            end
            S_EST:
            begin
                state_next = S_FB;
            end
            S_FB:
            begin
                mul_en     = 1'b1;
                state_next = S_STO;
            end
            S_STO:
            begin
                store_req.wr_en = 1'b1;
                wp_next         = wp_reg + ffd_pkg::ADDR_W'(1);
                if (fill_count_reg != ffd_pkg::FILL_W'(ffd_pkg::STORE_DEPTH))
                begin
                    fill_count_next = fill_count_reg + ffd_pkg::FILL_W'(1);
                end
                state_next = S_MIX;
            end
            S_MIX:
            begin
                mul_en     = 1'b1;
                mul_a      = ffd_pkg::MUL_W'(stored_reg);
                mul_b      = ffd_pkg::MUL_W'(mix_gain_reg);
                state_next = S_TAP;
            end
            S_TAP:
            begin
                mul_en     = 1'b1;
                mul_b      = ffd_pkg::MUL_W'(tap_gain_reg);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    sample_out_next = sat16(out_rnd[SUM_W-1:0]);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            wp_reg         <= ffd_pkg::ADDR_W'(ffd_pkg::STORE_DEPTH - 1);
            fill_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            sample_out_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            fill_count_reg <= fill_count_next;
            out_valid_reg  <= out_valid_next;
            sample_out_reg <= sample_out_next;
        end
    end

    // Datapath registers carry no control meaning and need no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            x_reg <= sample_in;
        end
        if (state_reg == S_RD0)
        begin
            y1_reg <= valid1 ? rd_data : '0;
        end
        if (state_reg == S_EST)
        begin
            est_reg <= est_next;
        end
        if (state_reg == S_STO)
        begin
            stored_reg <= stored_next;
        end
        if (state_reg == S_TAP)
        begin
            acc_reg <= product;
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

    ffd_store u_store
    (
        .clk     (clk),
        .req     (store_req),
        .rd_data (rd_data)
    );

    ffd_mul u_mul
    (
        .clk     (clk),
        .en      (mul_en),
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

`ifndef SYNTHESIS
    a_accept_starts_read : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_RD0)
        else $error("accepted transaction did not start the store read");

    a_result_from_last_step : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result shown outside the final step");

    a_write_advances_pointer : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_STO |=> wp_reg == $past(wp_reg) + ffd_pkg::ADDR_W'(1))
        else $error("write pointer did not advance after the store write");

    a_fill_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= ffd_pkg::FILL_W'(ffd_pkg::STORE_DEPTH))
        else $error("fill count beyond the store depth");

    a_no_overwrite_pending : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(sample_out_reg))
        else $error("pending result was overwritten");
`endif

endmodule
